// File: src/qse_pkg.sv
`default_nettype none

package qse_pkg;

   // element word width and default capacity of the cell row
   localparam int DATA_WIDTH   = 32;
   localparam int CAPACITY_DEF = 64;

   // one element word moving through the row
   typedef struct packed {
      logic                         valid;
      logic signed [DATA_WIDTH-1:0] value;
   } word_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

// File: src/qse_cell.sv
`default_nettype none

module qse_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire qse_pkg::word_type tok_in,
   input  wire qse_pkg::word_type shift_in,
   input  wire logic             shift_en,
   output qse_pkg::word_type     held,
   output qse_pkg::word_type     tok_out
);

   logic                                  held_valid_ff, held_valid_in;
   logic signed [qse_pkg::DATA_WIDTH-1:0] held_value_ff, held_value_in;
   logic                                  tok_valid_ff, tok_valid_in;
   logic signed [qse_pkg::DATA_WIDTH-1:0] tok_value_ff, tok_value_in;

   // on shift_en take the right neighbor's word; else keep the smaller word, hand the larger one to the right neighbor
   always_comb begin
      held_valid_in = held_valid_ff;
      held_value_in = held_value_ff;
      tok_valid_in  = 1'b0;
      tok_value_in  = tok_value_ff;
      if (shift_en) begin
         held_valid_in = shift_in.valid;
         held_value_in = shift_in.value;
      end else if (tok_in.valid) begin
         if (!held_valid_ff) begin
            held_valid_in = 1'b1;
            held_value_in = tok_in.value;
         end else if (tok_in.value < held_value_ff) begin
            held_value_in = tok_in.value;
            tok_valid_in  = 1'b1;
            tok_value_in  = held_value_ff;
         end else begin
            tok_valid_in  = 1'b1;
            tok_value_in  = tok_in.value;
         end
      end
   end

   // control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         tok_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         tok_valid_ff  <= tok_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      held_value_ff <= held_value_in;
      tok_value_ff  <= tok_value_in;
   end

   assign held.valid    = held_valid_ff;
   assign held.value    = held_value_ff;
   assign tok_out.valid = tok_valid_ff;
   assign tok_out.value = tok_value_ff;

endmodule

`default_nettype wire

// File: src/quicksort_engine.sv
`default_nettype none

// channel   ports                                    handshake
// req       req_value, req_last                      start high, busy low
// rsp       rsp_sorted_value, rsp_last_out,          rsp_valid strobe, one cycle
//           rsp_overflow
// csr       csr_wdata                                csr_we, no wait
//
// a set of N words is loaded one word per cycle while start is high, then
// the last word ripples down the cell row, then the set leaves one sorted
// word per cycle, smallest first.
// busy is high from the edge that takes the last word until the final word
// is out. reset clears the cells, the counters and the sequencer.
// results leave on consecutive cycles and cannot be stalled.

module quicksort_engine #(
   parameter int CAPACITY = qse_pkg::CAPACITY_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [qse_pkg::DATA_WIDTH-1:0] req_value,
   input  wire logic                                  req_last,
   output logic                                       rsp_valid,
   output logic signed [qse_pkg::DATA_WIDTH-1:0]      rsp_sorted_value,
   output logic                                       rsp_last_out,
   output logic                                       rsp_overflow,
   input  wire logic                                  csr_we,
   input  wire logic                                  csr_wdata
);

   localparam int CW = $clog2(CAPACITY + 1);

   qse_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      timer_ff, timer_in;
   logic               dropped_ff, dropped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [qse_pkg::DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               accept;
   logic               store;
   logic               shift_en;

   qse_pkg::word_type  tok  [CAPACITY];
   qse_pkg::word_type  held [CAPACITY];
   qse_pkg::word_type  shin [CAPACITY];

   // the row yields the same ascending order whatever pivot rule is chosen,
   // so the pivot word is taken but steers nothing
   logic               pivot_unused;
   assign pivot_unused = csr_we & csr_wdata;

   assign accept   = start && (state_ff == qse_pkg::ST_LOAD);
   assign store    = accept && (count_ff != CW'(CAPACITY));
   assign shift_en = (state_ff == qse_pkg::ST_DRAIN);

   // word entering the head of the row
   assign tok[0].valid = store;
   assign tok[0].value = req_value;

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i < CAPACITY - 1) begin : g_mid
         assign shin[i] = held[i+1];
         qse_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .tok_in   (tok[i]),
            .shift_in (shin[i]),
            .shift_en (shift_en),
            .held     (held[i]),
            .tok_out  (tok[i+1])
         );
      end else begin : g_end
         assign shin[i].valid = 1'b0;
         assign shin[i].value = held[i].value;
         qse_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .tok_in   (tok[i]),
            .shift_in (shin[i]),
            .shift_en (shift_en),
            .held     (held[i]),
            .tok_out  ()
         );
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qse_pkg::ST_LOAD: begin
            if (accept && req_last) state_in = qse_pkg::ST_SETTLE;
         end
         qse_pkg::ST_SETTLE: begin
            if (timer_ff == '0) state_in = qse_pkg::ST_DRAIN;
         end
         qse_pkg::ST_DRAIN: begin
            if (count_ff == CW'(1)) state_in = qse_pkg::ST_LOAD;
         end
         default: state_in = qse_pkg::ST_LOAD;
      endcase
   end

   // counters and result word
   always_comb begin
      count_in     = count_ff;
      timer_in     = timer_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         qse_pkg::ST_LOAD: begin
            timer_in = CW'(CAPACITY - 1);
            if (store) count_in = count_ff + CW'(1);
            if (accept && !store) dropped_in = 1'b1;
         end
         qse_pkg::ST_SETTLE: begin
            timer_in = timer_ff - CW'(1);
         end
         qse_pkg::ST_DRAIN: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = held[0].value;
            rsp_last_in  = (count_ff == CW'(1));
            rsp_ovf_in   = dropped_ff;
            count_in     = count_ff - CW'(1);
            if (count_ff == CW'(1)) dropped_in = 1'b0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qse_pkg::ST_LOAD;
         count_ff     <= '0;
         timer_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         timer_ff     <= timer_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign busy             = (state_ff != qse_pkg::ST_LOAD);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

`default_nettype wire

// File: verif/quicksort_engine_tb.sv
`default_nettype none

module quicksort_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_WIDTH  = qse_pkg::DATA_WIDTH;
   localparam int SLOTS       = qse_pkg::CAPACITY_DEF;
   localparam int SETTLE_WAIT = SLOTS + 8;
   localparam int WATCH_LIMIT = 4000;

   localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   // how the words of one set are filled
   typedef enum int {
      FILL_RANDOM,
      FILL_CLUSTER,
      FILL_RISING,
      FILL_FALLING,
      FILL_EDGES
   } fill_kind_type;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
      logic                         overflow;
   } sorted_word_type;

   // sort predictor plus queue of sorted words still owed by the block
   class sort_scoreboard;
      logic signed [DATA_WIDTH-1:0] element_row [SLOTS];
      int              fill;
      bit              lost;
      bit              middle_pivot;
      int              errors;
      sorted_word_type awaited [$];
      int              range_lo [$];
      int              range_hi [$];

      function new();
         fill = 0;
         lost = 0;
         middle_pivot = 0;
         errors = 0;
      endfunction

      function void set_pivot_rule(bit rule);
         middle_pivot = rule;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void swap_slots(int a, int b);
         logic signed [DATA_WIDTH-1:0] tmp;
         tmp = element_row[a];
         element_row[a] = element_row[b];
         element_row[b] = tmp;
      endfunction

      function void push_range(int lo, int hi);
         if (lo < hi && range_lo.size() < SLOTS) begin
            range_lo.push_back(lo);
            range_hi.push_back(hi);
         end
      endfunction

      // lomuto pass over [lo, hi], returns where the pivot lands
      function int partition(int lo, int hi);
         logic signed [DATA_WIDTH-1:0] pivot;
         int place;
         if (middle_pivot)
            swap_slots((lo + hi) >> 1, hi);
         pivot = element_row[hi];
         place = lo;
         for (int scan = lo; scan < hi; scan++) begin
            if (element_row[scan] < pivot) begin
               swap_slots(place, scan);
               place++;
            end
         end
         swap_slots(place, hi);
         return place;
      endfunction

      // range stack in place of recursion
      function void sort_row();
         int lo;
         int hi;
         int mid;
         range_lo.delete();
         range_hi.delete();
         if (fill < 2)
            return;
         push_range(0, fill - 1);
         while (range_lo.size() > 0) begin
            lo = range_lo.pop_back();
            hi = range_hi.pop_back();
            if (lo >= hi)
               continue;
            mid = partition(lo, hi);
            if (mid > lo)
               push_range(lo, mid - 1);
            push_range(mid + 1, hi);
         end
      endfunction

      // one input word taken by the block
      function void note_word(logic signed [DATA_WIDTH-1:0] value, logic last);
         sorted_word_type w;
         if (fill < SLOTS) begin
            element_row[fill] = value;
            fill++;
         end else begin
            lost = 1;
         end
         if (last) begin
            sort_row();
            for (int k = 0; k < fill; k++) begin
               w.value = element_row[k];
               w.last = (k == fill - 1);
               w.overflow = lost;
               awaited.push_back(w);
            end
            fill = 0;
            lost = 0;
         end
      endfunction

      // one output word seen on the strobe
      function void check_result(logic signed [DATA_WIDTH-1:0] value, logic last,
                                 logic overflow);
         sorted_word_type w;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected word, expected none, %s %0d last %0b overflow %0b",
                     $time, "actual value", value, last, overflow);
            return;
         end
         w = awaited.pop_front();
         if (value !== w.value) begin
            errors++;
            $display("%0t ns: sorted_value mismatch, expected %0d, actual %0d",
                     $time, w.value, value);
         end
         if (last !== w.last) begin
            errors++;
            $display("%0t ns: last_out mismatch, expected %0b, actual %0b",
                     $time, w.last, last);
         end
         if (overflow !== w.overflow) begin
            errors++;
            $display("%0t ns: overflow mismatch, expected %0b, actual %0b",
                     $time, w.overflow, overflow);
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [DATA_WIDTH-1:0] req_value;
   logic                         req_last;
   logic                         rsp_valid;
   logic signed [DATA_WIDTH-1:0] rsp_sorted_value;
   logic                         rsp_last_out;
   logic                         rsp_overflow;
   logic                         csr_we;
   logic                         csr_wdata;

   sort_scoreboard sb = new();
   int sender_idle_pct;
   int quiet_cycles;

   quicksort_engine #(
      .CAPACITY(SLOTS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_last_out    (rsp_last_out),
      .rsp_overflow    (rsp_overflow),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // result check and watchdog on handshakes
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid)
            sb.check_result(rsp_sorted_value, rsp_last_out, rsp_overflow);
         if (rsp_valid || (start && !busy))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCH_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // offer one word, optionally after a random gap
   task automatic send_word(input logic signed [DATA_WIDTH-1:0] value, input logic last);
      int gap;
      gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      req_last  <= last;
      do
         @(posedge clock);
      while (busy);
      sb.note_word(value, last);
   endtask

   // sender holds off until every owed word is out and the block is free
   task automatic wait_drained();
      start <= 1'b0;
      while (sb.pending() > 0 || busy)
         @(posedge clock);
   endtask

   task automatic write_pivot_rule(input bit rule);
      wait_drained();
      repeat (SETTLE_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= rule;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_pivot_rule(rule);
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] make_value(fill_kind_type kind, int k,
                                                                int size);
      logic signed [DATA_WIDTH-1:0] v;
      case (kind)
         FILL_CLUSTER: v = $signed($urandom_range(0, 6)) - 3;
         FILL_RISING:  v = k * 7919 - size * 4000;
         FILL_FALLING: v = size * 4000 - k * 7919;
         FILL_EDGES: begin
            case ($urandom_range(0, 6))
               0: v = WORD_MIN;
               1: v = WORD_MAX;
               2: v = WORD_MIN + 1;
               3: v = WORD_MAX - 1;
               4: v = -1;
               5: v = 0;
               default: v = 1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_set(input int size, input fill_kind_type kind);
      for (int k = 0; k < size; k++)
         send_word(make_value(kind, k, size), k == size - 1);
   endtask

   // one idling profile and pivot rule, a big set, then mostly small sets
   task automatic run_phase(input int idle_pct, input bit rule, input int big_size,
                            input int target);
      int sent;
      int size;
      bit paused;
      write_pivot_rule(rule);
      sender_idle_pct = idle_pct;
      send_set(big_size, fill_kind_type'($urandom_range(0, 4)));
      sent = 0;
      paused = 0;
      while (sent < target) begin
         size = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
         send_set(size, fill_kind_type'($urandom_range(0, 4)));
         sent += size;
         if (!paused && sent > target / 2) begin
            wait_drained();
            paused = 1;
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      req_last  = 1'b0;
      csr_we    = 1'b0;
      csr_wdata = 1'b0;
      sender_idle_pct = 15;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single words, extremes, duplicates, equal sets
      write_pivot_rule(1'b0);
      send_word(WORD_MIN, 1'b1);
      send_word(WORD_MAX, 1'b1);
      send_word(WORD_MAX, 1'b0);
      send_word(WORD_MIN, 1'b1);
      send_word(0, 1'b0);
      send_word(-1, 1'b0);
      send_word(1, 1'b0);
      send_word(-1, 1'b0);
      send_word(0, 1'b1);
      send_word(5, 1'b0);
      send_word(5, 1'b0);
      send_word(5, 1'b0);
      send_word(5, 1'b1);
      write_pivot_rule(1'b1);
      send_word(3, 1'b0);
      send_word(WORD_MIN, 1'b0);
      send_word(WORD_MAX, 1'b0);
      send_word(-7, 1'b0);
      send_word(3, 1'b1);

      // random: full store, then an overflow set where the last two words are dropped, then small sets only
      run_phase(15, 1'b1, SLOTS, 6);
      run_phase(45, 1'b0, SLOTS + 2, 6);
      run_phase(0, 1'b1, 0, 6);

      wait_drained();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (sb.pending() > 0)
            $display("%0t ns: %0d sorted words never arrived", $time, sb.pending());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
